@@ rtl/core/mwc_pkg.sv @@
// ----------------------------------------------------------------------------
// mwc_pkg
// Shared widths, register codes, reset values and lane types for the
// mecanum wheel command pipeline.
// ----------------------------------------------------------------------------
package mwc_pkg;

    // wheel order: front left, front right, rear left, rear right
    localparam int WHEELS     = 4;
    localparam int VEL_W      = 16;
    localparam int WHEEL_W    = 18;
    localparam int MAG_W      = 17;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int LIMIT_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int RPM_W      = 16;
    localparam int MASK_W     = 4;
    localparam int RPM_SHIFT  = 18;
    localparam int MUL_W      = MAG_W + GAIN_W;
    localparam int SHR_W      = MUL_W - RPM_SHIFT;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_CAP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MASK = 2'd3;

    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 17'd2048;
    localparam logic [GAIN_W-1:0]  RPM_GAIN_RST    = 16'd60928;
    localparam logic [RPM_W-1:0]   RPM_CAP_RST     = 16'd3000;
    localparam logic [MASK_W-1:0]  MIRROR_MASK_RST = 4'd10;

    // stream widths, one lane of the result is a dir bit and an rpm field
    localparam int S_DATA_W = 48;
    localparam int LANE_W   = 1 + RPM_W;
    localparam int M_DATA_W = 72;

    typedef logic signed [WHEEL_W-1:0] wheel_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [PROD_W-1:0]         prod_t;
    typedef logic [MUL_W-1:0]          mul_t;
    typedef logic [RPM_W-1:0]          rpm_t;

    // per-item side information that rides along the divider
    typedef struct packed {
        logic [WHEELS-1:0] neg;
        logic              scale;
        mag_t [WHEELS-1:0] mag;
    } side_t;

endpackage

@@ rtl/core/mecanum_wheel_command_unit.sv @@
// ----------------------------------------------------------------------------
// mecanum_wheel_command_unit
// Mecanum inverse kinematics: body velocity in, four wheel rpm commands out.
// ----------------------------------------------------------------------------
// Usage
//   s_ beats carry one body velocity (side, forward, turn, 1/1024 m/s each);
//   m_ beats carry, per wheel (FL FR RL RR), a direction bit and an rpm
//   magnitude. Exactly one m_ beat leaves for every s_ beat, in order.
//   From s_ acceptance to m_tvalid a beat passes two front stages,
//   17 divider stages (one quotient bit each, sets the depth) and two back
//   stages. One beat per cycle is sustained while m_tready is high; the rpm
//   gain multiply and each divider step are the per-cycle units.
//   Every stage has its own valid bit and loads when it is empty or the
//   stage after it moves, so when m_tready is low beats keep entering until
//   the pipeline is full; s_tready drops only then. Nothing is lost or
//   repeated across a stall.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the
//   clock edge and are meant for idle periods only.
//   Synchronous active-low reset empties the pipeline and loads the register
//   defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mecanum_wheel_command_unit
    import mwc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // velocity beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // side_speed, forward_speed, turn_speed
    // wheel command beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // front_left_dir, front_left_rpm,
                                             // front_right_dir, front_right_rpm,
                                             // rear_left_dir, rear_left_rpm,
                                             // rear_right_dir, rear_right_rpm, zero pad
);

    logic [LIMIT_W-1:0] speed_limit_reg;
    logic [GAIN_W-1:0]  rpm_gain_reg;
    logic [RPM_W-1:0]   rpm_cap_reg;
    logic [MASK_W-1:0]  mirror_mask_reg;

    logic               f_valid;
    logic               f_ready;
    prod_t [WHEELS-1:0] f_num;
    mag_t               f_den;
    side_t              f_side;
    logic               d_valid;
    logic               d_ready;
    mag_t [WHEELS-1:0]  d_quot;
    side_t              d_side;
    logic [WHEELS-1:0]  b_dir;
    rpm_t [WHEELS-1:0]  b_rpm;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit_reg <= SPEED_LIMIT_RST;
            rpm_gain_reg    <= RPM_GAIN_RST;
            rpm_cap_reg     <= RPM_CAP_RST;
            mirror_mask_reg <= MIRROR_MASK_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_RPM_GAIN:    rpm_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_RPM_CAP:     rpm_cap_reg     <= cfg_wdata[RPM_W-1:0];
                REG_MIRROR_MASK: mirror_mask_reg <= cfg_wdata[MASK_W-1:0];
            endcase
        end
    end

    // wheel sums, max and scale products
    mwc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_side_speed    (s_tdata[VEL_W-1:0]),
        .in_forward_speed (s_tdata[2*VEL_W-1:VEL_W]),
        .in_turn_speed    (s_tdata[3*VEL_W-1:2*VEL_W]),
        .speed_limit      (speed_limit_reg),
        .out_valid        (f_valid),
        .out_ready        (f_ready),
        .out_num          (f_num),
        .out_den          (f_den),
        .out_side         (f_side)
    );

    // limit / max scaling divide
    mwc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_num    (f_num),
        .in_den    (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_quot  (d_quot),
        .out_side  (d_side)
    );

    // rpm conversion and output register
    mwc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (d_valid),
        .in_ready    (d_ready),
        .in_quot     (d_quot),
        .in_side     (d_side),
        .rpm_gain    (rpm_gain_reg),
        .rpm_cap     (rpm_cap_reg),
        .mirror_mask (mirror_mask_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_dir     (b_dir),
        .out_rpm     (b_rpm)
    );

    // pack the result beat
    always_comb begin
        m_tdata = '0;
        for (int l = 0; l < WHEELS; l++) begin
            m_tdata[l*LANE_W +: LANE_W] = {b_rpm[l], b_dir[l]};
        end
    end

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output side can move");

endmodule

@@ rtl/core/mwc_front.sv @@
// ----------------------------------------------------------------------------
// mwc_front
// Two stages: wheel sums with sign and magnitude, then the largest magnitude,
// the scale decision and the magnitude-times-limit products for the divider.
// ----------------------------------------------------------------------------
module mwc_front
    import mwc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VEL_W-1:0]   in_side_speed,
    input  logic signed [VEL_W-1:0]   in_forward_speed,
    input  logic signed [VEL_W-1:0]   in_turn_speed,
    input  logic [LIMIT_W-1:0]        speed_limit,
    output logic                      out_valid,
    input  logic                      out_ready,
    output prod_t [WHEELS-1:0]        out_num,
    output mag_t                      out_den,
    output side_t                     out_side
);

    logic              vld1_reg;
    logic              vld2_reg;
    logic              rdy1;
    logic              rdy2;
    mag_t [WHEELS-1:0] mag1_reg;
    logic [WHEELS-1:0] neg1_reg;
    mag_t [WHEELS-1:0] mag1_next;
    logic [WHEELS-1:0] neg1_next;
    prod_t [WHEELS-1:0] num2_reg;
    mag_t              den2_reg;
    side_t             side2_reg;
    prod_t [WHEELS-1:0] num2_next;
    mag_t              max01;
    mag_t              max23;
    mag_t              max_all;

    assign rdy2     = !vld2_reg || out_ready;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    // wheel sums, sign and magnitude
    always_comb begin
        wheel_t s;
        wheel_t f;
        wheel_t t;
        wheel_t w [WHEELS];
        wheel_t nw;
        s = {{(WHEEL_W-VEL_W){in_side_speed[VEL_W-1]}}, in_side_speed};
        f = {{(WHEEL_W-VEL_W){in_forward_speed[VEL_W-1]}}, in_forward_speed};
        t = {{(WHEEL_W-VEL_W){in_turn_speed[VEL_W-1]}}, in_turn_speed};
        w[0] = f + s + t;
        w[1] = f - s - t;
        w[2] = f - s + t;
        w[3] = f + s - t;
        for (int l = 0; l < WHEELS; l++) begin
            nw           = -w[l];
            neg1_next[l] = w[l][WHEEL_W-1];
            mag1_next[l] = w[l][WHEEL_W-1] ? nw[MAG_W-1:0] : w[l][MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (rdy1) begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
        end
    end

    // largest magnitude and products for the scaling divide
    assign max01   = (mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1];
    assign max23   = (mag1_reg[2] > mag1_reg[3]) ? mag1_reg[2] : mag1_reg[3];
    assign max_all = (max01 > max23) ? max01 : max23;

    always_comb begin
        for (int l = 0; l < WHEELS; l++) begin
            num2_next[l] = prod_t'(mag1_reg[l]) * prod_t'(speed_limit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (rdy2) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && vld1_reg) begin
            num2_reg        <= num2_next;
            den2_reg        <= max_all;
            side2_reg.neg   <= neg1_reg;
            side2_reg.scale <= (max_all > speed_limit);
            side2_reg.mag   <= mag1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign out_num   = num2_reg;
    assign out_den   = den2_reg;
    assign out_side  = side2_reg;

endmodule

@@ rtl/core/mwc_div.sv @@
// ----------------------------------------------------------------------------
// mwc_div
// Pipelined restoring divider, one quotient bit per stage, four lanes over a
// shared divisor. The quotient of each lane is known to fit in MAG_W bits.
// ----------------------------------------------------------------------------
module mwc_div
    import mwc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  prod_t [WHEELS-1:0]  in_num,
    input  mag_t                in_den,
    input  side_t               in_side,
    output logic                out_valid,
    input  logic                out_ready,
    output mag_t [WHEELS-1:0]   out_quot,
    output side_t               out_side
);

    localparam int STEPS = MAG_W;

    logic [STEPS-1:0]   vld_reg;
    logic [STEPS:0]     rdy;
    prod_t [WHEELS-1:0] work_reg  [STEPS];
    mag_t               den_reg   [STEPS];
    side_t              side_reg  [STEPS];
    prod_t [WHEELS-1:0] src_work  [STEPS];
    mag_t               src_den   [STEPS];
    side_t              src_side  [STEPS];
    logic [STEPS-1:0]   src_valid;
    prod_t [WHEELS-1:0] work_next [STEPS];
    logic               rem_ok;
    logic               quot_ok;

    assign rdy[STEPS] = out_ready;
    assign in_ready   = rdy[0];

    // word per lane: partial remainder on top, dividend bits then quotient below
    for (genvar s = 0; s < STEPS; s++) begin : g_step
        if (s == 0) begin : g_first
            assign src_work[s]  = in_num;
            assign src_den[s]   = in_den;
            assign src_side[s]  = in_side;
            assign src_valid[s] = in_valid;
        end else begin : g_next
            assign src_work[s]  = work_reg[s-1];
            assign src_den[s]   = den_reg[s-1];
            assign src_side[s]  = side_reg[s-1];
            assign src_valid[s] = vld_reg[s-1];
        end

        assign rdy[s] = !vld_reg[s] || rdy[s+1];

        // one compare and subtract per lane
        always_comb begin
            logic [MAG_W:0] trial;
            logic [MAG_W:0] diff;
            for (int l = 0; l < WHEELS; l++) begin
                trial = {src_work[s][l][PROD_W-1:MAG_W], src_work[s][l][MAG_W-1]};
                diff  = trial - {1'b0, src_den[s]};
                if (trial >= {1'b0, src_den[s]}) begin
                    work_next[s][l] = {diff[MAG_W-1:0], src_work[s][l][MAG_W-2:0], 1'b1};
                end else begin
                    work_next[s][l] = {trial[MAG_W-1:0], src_work[s][l][MAG_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (rdy[s]) begin
                vld_reg[s] <= src_valid[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[s] && src_valid[s]) begin
                work_reg[s] <= work_next[s];
                den_reg[s]  <= src_den[s];
                side_reg[s] <= src_side[s];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

    always_comb begin
        for (int l = 0; l < WHEELS; l++) begin
            out_quot[l] = work_reg[STEPS-1][l][MAG_W-1:0];
        end
    end

    // scaled items: final remainder below divisor, quotient never above magnitude
    always_comb begin
        rem_ok  = 1'b1;
        quot_ok = 1'b1;
        for (int l = 0; l < WHEELS; l++) begin
            if (work_reg[STEPS-1][l][PROD_W-1:MAG_W] >= den_reg[STEPS-1]) begin
                rem_ok = 1'b0;
            end
            if (work_reg[STEPS-1][l][MAG_W-1:0] > side_reg[STEPS-1].mag[l]) begin
                quot_ok = 1'b0;
            end
        end
    end

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_side.scale) |-> rem_ok)
        else $error("divider remainder not below divisor");

    a_quot_not_above_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_side.scale) |-> quot_ok)
        else $error("scaled wheel speed exceeds its unscaled magnitude");

endmodule

@@ rtl/core/mwc_back.sv @@
// ----------------------------------------------------------------------------
// mwc_back
// Two stages: rpm gain multiply, then shift, sign handling, rpm cap and the
// direction bit with mirroring. The second stage is the output register.
// ----------------------------------------------------------------------------
module mwc_back
    import mwc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  mag_t [WHEELS-1:0]   in_quot,
    input  side_t               in_side,
    input  logic [GAIN_W-1:0]   rpm_gain,
    input  logic [RPM_W-1:0]    rpm_cap,
    input  logic [MASK_W-1:0]   mirror_mask,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WHEELS-1:0]   out_dir,
    output rpm_t [WHEELS-1:0]   out_rpm
);

    logic              vld1_reg;
    logic              vld2_reg;
    logic              rdy1;
    logic              rdy2;
    mul_t [WHEELS-1:0] mul1_reg;
    logic [WHEELS-1:0] neg1_reg;
    mul_t [WHEELS-1:0] mul1_next;
    logic [WHEELS-1:0] dir2_reg;
    rpm_t [WHEELS-1:0] rpm2_reg;
    logic [WHEELS-1:0] dir2_next;
    rpm_t [WHEELS-1:0] rpm2_next;

    assign rdy2     = !vld2_reg || out_ready;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    // pick scaled or plain magnitude, times the gain
    always_comb begin
        mag_t a;
        for (int l = 0; l < WHEELS; l++) begin
            a            = in_side.scale ? in_quot[l] : in_side.mag[l];
            mul1_next[l] = mul_t'(a) * mul_t'(rpm_gain);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (rdy1) begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            mul1_reg <= mul1_next;
            neg1_reg <= in_side.neg;
        end
    end

    // shift to rpm, cap and direction; the product bound keeps the shifted
    // value under 2^15, so int16 saturation has nothing left to clip
    always_comb begin
        logic [SHR_W-1:0] r;
        rpm_t             m;
        logic             neg_eff;
        for (int l = 0; l < WHEELS; l++) begin
            r            = mul1_reg[l][MUL_W-1:RPM_SHIFT];
            m            = rpm_t'(r);
            neg_eff      = neg1_reg[l] && (r != '0);
            rpm2_next[l] = (m > rpm_cap) ? rpm_cap : m;
            dir2_next[l] = neg_eff ^ mirror_mask[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (rdy2) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && vld1_reg) begin
            dir2_reg <= dir2_next;
            rpm2_reg <= rpm2_next;
        end
    end

    assign out_valid = vld2_reg;
    assign out_dir   = dir2_reg;
    assign out_rpm   = rpm2_reg;

endmodule

@@ dv/mwc_wheel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwc_wheel_checker
// Watches the velocity, wheel command and register write ports of the mecanum
// wheel command unit. Each accepted velocity beat is turned into the expected
// four wheel commands, which are queued in order and compared field by field
// with every accepted wheel command beat.
// ----------------------------------------------------------------------------
module mwc_wheel_checker
    import mwc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // side_speed, forward_speed, turn_speed
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,   // fl dir, fl rpm, fr dir, fr rpm,
                                             // rl dir, rl rpm, rr dir, rr rpm, pad
    output int unsigned           cmds_pending,
    output int unsigned           cmds_checked,
    output int unsigned           fail_count
);

    // shadow copy of the register file
    logic [LIMIT_W-1:0] speed_limit;
    logic [GAIN_W-1:0]  rpm_gain;
    logic [RPM_W-1:0]   rpm_cap;
    logic [MASK_W-1:0]  mirror_mask;

    logic [M_DATA_W-1:0] wheel_cmd_q[$];
    string               wheel_name[WHEELS] = '{"front left", "front right",
                                                "rear left", "rear right"};

    // body velocity to four packed wheel commands under the current settings
    function automatic logic [M_DATA_W-1:0] wheel_commands(input logic [S_DATA_W-1:0] vel);
        logic signed [VEL_W-1:0] side, fwd, turn;
        wheel_t                  w[WHEELS];
        longint                  sw;
        longint unsigned         mag, peak, rpm;
        logic                    neg;
        logic [M_DATA_W-1:0]     cmd;
        int                      i;
        side = vel[0 +: VEL_W];
        fwd  = vel[VEL_W +: VEL_W];
        turn = vel[2*VEL_W +: VEL_W];
        w[0] = wheel_t'(fwd) + wheel_t'(side) + wheel_t'(turn);
        w[1] = wheel_t'(fwd) - wheel_t'(side) - wheel_t'(turn);
        w[2] = wheel_t'(fwd) - wheel_t'(side) + wheel_t'(turn);
        w[3] = wheel_t'(fwd) + wheel_t'(side) - wheel_t'(turn);
        peak = 0;
        for (i = 0; i < WHEELS; i++) begin
            sw  = w[i];
            mag = (sw < 0) ? -sw : sw;
            if (mag > peak) peak = mag;
        end
        cmd = '0;
        for (i = 0; i < WHEELS; i++) begin
            sw  = w[i];
            mag = (sw < 0) ? -sw : sw;
            // all wheels shrink by the same ratio when the fastest is over the limit
            if (peak > speed_limit) mag = (mag * speed_limit) / peak;
            rpm = (mag * rpm_gain) >> RPM_SHIFT;
            // a zero rpm counts as forward for the direction bit
            neg = (sw < 0) && (rpm != 0);
            if (neg && rpm > 32768) rpm = 32768;
            if (!neg && rpm > 32767) rpm = 32767;
            if (rpm > rpm_cap) rpm = rpm_cap;
            cmd[i*LANE_W]            = neg ^ mirror_mask[i];
            cmd[i*LANE_W+1 +: RPM_W] = rpm[RPM_W-1:0];
        end
        return cmd;
    endfunction

    // predict on velocity beats, compare on wheel command beats
    always @(posedge aclk) begin
        logic [M_DATA_W-1:0] exp_cmd;
        logic                bad;
        int                  i;
        if (!aresetn) begin
            speed_limit  = SPEED_LIMIT_RST;
            rpm_gain     = RPM_GAIN_RST;
            rpm_cap      = RPM_CAP_RST;
            mirror_mask  = MIRROR_MASK_RST;
            wheel_cmd_q.delete();
            cmds_pending <= 0;
        end else begin
            if (s_tvalid && s_tready) wheel_cmd_q.push_back(wheel_commands(s_tdata));
            if (m_tvalid && m_tready) begin
                if (wheel_cmd_q.size() == 0) begin
                    $display("%0t: unexpected wheel command beat, expected none, got %h",
                             $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_cmd = wheel_cmd_q.pop_front();
                    bad     = 1'b0;
                    for (i = 0; i < WHEELS; i++) begin
                        if (m_tdata[i*LANE_W] !== exp_cmd[i*LANE_W]) begin
                            $display("%0t: %s dir expected %0d got %0d", $time,
                                     wheel_name[i], exp_cmd[i*LANE_W], m_tdata[i*LANE_W]);
                            bad = 1'b1;
                        end
                        if (m_tdata[i*LANE_W+1 +: RPM_W] !== exp_cmd[i*LANE_W+1 +: RPM_W]) begin
                            $display("%0t: %s rpm expected %0d got %0d", $time,
                                     wheel_name[i], exp_cmd[i*LANE_W+1 +: RPM_W],
                                     m_tdata[i*LANE_W+1 +: RPM_W]);
                            bad = 1'b1;
                        end
                    end
                    if (bad) fail_count <= fail_count + 1;
                    cmds_checked <= cmds_checked + 1;
                end
            end
            // register writes land at the edge, only ever while idle
            if (cfg_we) begin
                case (cfg_index)
                    REG_SPEED_LIMIT: speed_limit = cfg_wdata[LIMIT_W-1:0];
                    REG_RPM_GAIN:    rpm_gain    = cfg_wdata[GAIN_W-1:0];
                    REG_RPM_CAP:     rpm_cap     = cfg_wdata[RPM_W-1:0];
                    REG_MIRROR_MASK: mirror_mask = cfg_wdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            cmds_pending <= wheel_cmd_q.size();
        end
    end

endmodule

@@ dv/mecanum_wheel_command_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_command_unit_tb
// Drives body velocity beats and register settings into the wheel command
// unit: directed extremes first, then random velocities under a series of
// settings, with random gaps and stalls on both streams and one long stall
// on the wheel command side. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module mecanum_wheel_command_unit_tb;
    import mwc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 120;
    localparam int DRAIN_WAIT  = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // side_speed, forward_speed, turn_speed
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // fl dir, fl rpm, fr dir, fr rpm,
                                      // rl dir, rl rpm, rr dir, rr rpm, pad

    int unsigned cmds_pending;
    int unsigned cmds_checked;
    int unsigned fail_count;
    int unsigned cmds_sent;
    int unsigned settings_used;
    int unsigned cycle_count;
    bit          hold_now;
    bit          tight;

    mecanum_wheel_command_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mwc_wheel_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cmds_pending (cmds_pending),
        .cmds_checked (cmds_checked),
        .fail_count   (fail_count)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding",
                     cycle_count, cmds_pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VEL_W-1:0] rand_speed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return VEL_W'($urandom);
        if (r < 75) return VEL_W'($urandom_range(0, 4000)) - VEL_W'(2000);
        if (r < 85) return VEL_W'($urandom_range(0, 600)) - VEL_W'(300);
        if (r < 95) begin
            case ($urandom_range(0, 3))
                0: return 16'h7fff;
                1: return 16'h8000;
                2: return 16'h7ffe;
                default: return 16'h8001;
            endcase
        end
        return '0;
    endfunction

    // wheel command side: runs of ready, random stalls, one long hold on request
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_now) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_now = 1'b0;
            end else begin
                int run, stall;
                run   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
                stall = pick_gap();
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_velocity(input logic [VEL_W-1:0] side, input logic [VEL_W-1:0] fwd,
                                 input logic [VEL_W-1:0] turn);
        int gap;
        gap = tight ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {turn, fwd, side};
        do @(posedge aclk); while (!s_tready);
        cmds_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_velocity(rand_speed(), rand_speed(), rand_speed());
        s_tvalid <= 1'b0;
    endtask

    // all four registers, written once every expected command is back
    task automatic load_settings(input logic [LIMIT_W-1:0] limit, input logic [GAIN_W-1:0] gain,
                                 input logic [RPM_W-1:0] cap, input logic [MASK_W-1:0] mask);
        do @(posedge aclk); while (cmds_pending != 0);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SPEED_LIMIT;
        cfg_wdata <= CFG_DATA_W'(limit);
        @(posedge aclk);
        cfg_index <= REG_RPM_GAIN;
        cfg_wdata <= CFG_DATA_W'(gain);
        @(posedge aclk);
        cfg_index <= REG_RPM_CAP;
        cfg_wdata <= CFG_DATA_W'(cap);
        @(posedge aclk);
        cfg_index <= REG_MIRROR_MASK;
        cfg_wdata <= CFG_DATA_W'(mask);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // a few extremes under each new setting
    task automatic send_corners();
        send_velocity(16'h7fff, 16'h7fff, 16'h7fff);
        send_velocity(16'h8000, 16'h8000, 16'h8000);
        send_velocity(16'h0001, 16'h0000, 16'hffff);
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_SPEED_LIMIT;
        cfg_wdata   <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cycle_count <= 0;
        hold_now      = 1'b0;
        tight         = 1'b0;
        cmds_sent     = 0;
        settings_used = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed, reset settings
        send_velocity(16'h0000, 16'h0000, 16'h0000);
        send_velocity(16'h7fff, 16'h7fff, 16'h7fff);
        send_velocity(16'h8000, 16'h8000, 16'h8000);
        send_velocity(16'h7fff, 16'h8000, 16'h7fff);
        send_velocity(16'h8000, 16'h7fff, 16'h8000);
        send_velocity(16'd1000, 16'd0, 16'd0);
        send_velocity(16'd0, -16'sd1000, 16'd0);
        send_velocity(16'd0, 16'd0, 16'd500);
        // tiny wheels round to zero rpm, negative ones must read as forward
        send_velocity(-16'sd1, 16'd0, 16'd0);
        send_velocity(16'd3, 16'd0, 16'd0);
        // fastest wheel right at the limit, then just past it
        send_velocity(16'd0, 16'd2048, 16'd0);
        send_velocity(16'd0, 16'd2049, 16'd0);
        send_velocity(16'd0, -16'sd2049, 16'd0);
        send_velocity(16'd683, 16'd683, 16'd682);
        send_velocity(16'd100, 16'd200, -16'sd50);
        send_velocity(-16'sd2000, 16'd500, 16'd1500);

        // back-to-back beats against a long output stall so the pipe fills up
        hold_now = 1'b1;
        tight    = 1'b1;
        repeat (60) send_velocity(rand_speed(), rand_speed(), rand_speed());
        tight = 1'b0;
        send_random(60);

        // zero limit: every nonzero wheel scales to zero
        load_settings('0, 16'hffff, 16'hffff, 4'h0);
        send_corners();
        send_random(60);

        // limit never reached, full gain, all wheels mirrored
        load_settings({LIMIT_W{1'b1}}, 16'hffff, 16'hffff, 4'hf);
        send_corners();
        send_random(60);

        // smallest nonzero limit, zero gain and zero cap
        load_settings(17'd1, 16'h0000, 16'h0000, 4'h5);
        send_corners();
        send_random(60);

        // random settings, mostly with a reachable limit and an active cap
        repeat (4) begin
            load_settings(($urandom_range(0, 1) != 0) ? LIMIT_W'($urandom_range(0, 6000))
                                                      : LIMIT_W'($urandom),
                          GAIN_W'($urandom),
                          ($urandom_range(0, 1) != 0) ? RPM_W'($urandom_range(0, 3000))
                                                      : RPM_W'($urandom),
                          MASK_W'($urandom));
            send_corners();
            send_random(45);
        end

        // drain, then allow for stray beats
        do @(posedge aclk); while (cmds_pending != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("sent %0d velocity commands under %0d register settings", cmds_sent,
                 settings_used);
        $display("checked %0d wheel command beats, %0d with errors", cmds_checked, fail_count);
        if (fail_count == 0 && cmds_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
